[rtl/nearest_color_redmean_search_assert.svh]
// assertion macros shared by the checker
`ifndef NEAREST_COLOR_REDMEAN_SEARCH_ASSERT_SVH
`define NEAREST_COLOR_REDMEAN_SEARCH_ASSERT_SVH

// same-cycle implication
`define NCRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ncrs assertion failed");

// next-cycle implication
`define NCRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ncrs assertion failed");

`endif

[rtl/ncrs_pkg.sv]
`default_nettype none
package ncrs_pkg;

  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int CH_W          = 8;
  localparam int SQ_W          = 16;
  localparam int WT_W          = 10;
  localparam int PROD_W        = 26;
  localparam int DIST_W        = 28;
  localparam int MAX_TILES_DEF = 1024;
  localparam int WT_R_BASE     = 512;
  localparam int WT_B_BASE     = 767;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] tile_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } result_t;

  // control tag that travels with each entry through the pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ctl_t;

endpackage
`default_nettype wire

[rtl/ncrs_table.sv]
`default_nettype none
module ncrs_table
  import ncrs_pkg::*;
#(
  parameter int MAX_TILES = MAX_TILES_DEF,
  parameter int AW        = $clog2(MAX_TILES)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire color_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output color_t             rdata
);

  color_t mem [MAX_TILES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/ncrs_dist.sv]
`default_nettype none
module ncrs_dist
  import ncrs_pkg::*;
#(
  parameter int AW = $clog2(MAX_TILES_DEF)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_t              ctl_in,
  input  wire logic [AW-1:0]     idx_in,
  input  wire color_t            entry,
  input  wire color_t            query,
  output ctl_t                   ctl_out,
  output logic [AW-1:0]          idx_out,
  output logic [DIST_W-1:0]      dist_out
);

  logic [CH_W-1:0]   dr, dg, db;
  logic [CH_W:0]     rsum;
  logic [WT_W-1:0]   wr, wb;

  ctl_t              ctl1, ctl2;
  logic [AW-1:0]     idx1, idx2;
  logic [SQ_W-1:0]   dr2, dg2, db2;
  logic [CH_W-1:0]   rm;
  logic [PROD_W-1:0] pr, pg, pb;

  always_comb begin
    dr   = (entry.red > query.red) ? entry.red - query.red : query.red - entry.red;
    dg   = (entry.green > query.green) ? entry.green - query.green
                                       : query.green - entry.green;
    db   = (entry.blue > query.blue) ? entry.blue - query.blue
                                     : query.blue - entry.blue;
    rsum = {1'b0, entry.red} + {1'b0, query.red};
    wr   = WT_W'(WT_R_BASE) + WT_W'(rm);
    wb   = WT_W'(WT_B_BASE) - WT_W'(rm);
  end

  // control tags (valid, first, last)
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl_out <= '0;
    end else begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl_out <= ctl2;
    end
  end

  // squares, then weighted products, then sum
  always_ff @(posedge clk) begin
    idx1     <= idx_in;
    dr2      <= SQ_W'(dr) * SQ_W'(dr);
    dg2      <= SQ_W'(dg) * SQ_W'(dg);
    db2      <= SQ_W'(db) * SQ_W'(db);
    rm       <= rsum[CH_W:1];
    idx2     <= idx1;
    pr       <= PROD_W'(wr) * PROD_W'(dr2);
    pg       <= {dg2, 10'b0};
    pb       <= PROD_W'(wb) * PROD_W'(db2);
    idx_out  <= idx2;
    dist_out <= DIST_W'(pr) + DIST_W'(pg) + DIST_W'(pb);
  end

endmodule
`default_nettype wire

[rtl/nearest_color_redmean_search.sv]
`default_nettype none
// Nearest tile color search by redmean distance. A load (action 0) writes one
// table entry and gives no result; loads may follow each other every cycle. A
// query (action 1) scans entries 0 to n-1, one per cycle through the single
// table read port and the shared distance pipeline, where n is tile_count held
// to 1..MAX_TILES. busy rises after a query is taken and falls once its last
// entry has left the pipeline; requests wait while busy is high. The answer
// appears on result for exactly one cycle with result_valid high, in the cycle
// busy falls; the receiver cannot stall it and must capture it then. tile_count
// must be written only while busy is low; the block does not enforce it. Table
// entries have no reset: a query must only reach entries that were loaded.
module nearest_color_redmean_search
  import ncrs_pkg::*;
#(
  parameter int MAX_TILES = MAX_TILES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire request_t         request,
  output logic                  result_valid,
  output result_t               result,
  input  wire logic             tile_count_we,
  input  wire logic [CNT_W-1:0] tile_count_data
);

  localparam int AW = $clog2(MAX_TILES);

  state_t            state, state_next;
  logic [AW-1:0]     addr, addr_next;
  logic [AW-1:0]     last_addr, last_addr_next;
  logic [CNT_W-1:0]  tile_count;
  color_t            query;
  logic [31:0]       cnt32, last32;

  logic              xfer;
  logic              load_we;
  color_t            rd_color;

  ctl_t              ctl0;
  logic [AW-1:0]     idx0;
  ctl_t              d_ctl;
  logic [AW-1:0]     d_idx;
  logic [DIST_W-1:0] d_dist;

  logic [AW-1:0]     best_idx, best_idx_next;
  logic [DIST_W-1:0] best_dist, best_dist_next;

  assign busy    = (state != ST_IDLE);
  assign xfer    = start && !busy;
  assign load_we = xfer && (request.action == ACT_LOAD)
                   && (32'(request.tile_index) < 32'(MAX_TILES));

  always_comb begin
    cnt32 = 32'(tile_count);
    if (cnt32 == 32'd0) begin
      last32 = 32'd0;
    end else if (cnt32 > 32'(MAX_TILES)) begin
      last32 = 32'(MAX_TILES) - 32'd1;
    end else begin
      last32 = cnt32 - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tile_count <= CNT_W'(1);
    end else begin
      state <= state_next;
      if (tile_count_we) begin
        tile_count <= tile_count_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr      <= addr_next;
    last_addr <= last_addr_next;
    if (xfer) begin
      query <= '{red: request.red, green: request.green, blue: request.blue};
    end
  end

  always_comb begin
    state_next     = state;
    addr_next      = addr;
    last_addr_next = last_addr;
    case (state)
      ST_IDLE: begin
        if (xfer && (request.action == ACT_QUERY)) begin
          state_next     = ST_SCAN;
          addr_next      = '0;
          last_addr_next = AW'(last32);
        end
      end
      ST_SCAN: begin
        addr_next = addr + AW'(1);
        if (addr == last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (d_ctl.valid && d_ctl.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  ncrs_table #(
    .MAX_TILES(MAX_TILES),
    .AW       (AW)
  ) u_table (
    .clk  (clk),
    .we   (load_we),
    .waddr(AW'(request.tile_index)),
    .wdata('{red: request.red, green: request.green, blue: request.blue}),
    .raddr(addr),
    .rdata(rd_color)
  );

  // tag aligned with the registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
    end else begin
      ctl0.valid <= (state == ST_SCAN);
      ctl0.first <= (addr == '0);
      ctl0.last  <= (addr == last_addr);
    end
  end

  always_ff @(posedge clk) begin
    idx0 <= addr;
  end

  ncrs_dist #(
    .AW(AW)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl0),
    .idx_in  (idx0),
    .entry   (rd_color),
    .query   (query),
    .ctl_out (d_ctl),
    .idx_out (d_idx),
    .dist_out(d_dist)
  );

  // strict less-than keeps the first index on ties
  always_comb begin
    best_idx_next  = best_idx;
    best_dist_next = best_dist;
    if (d_ctl.first || (d_dist < best_dist)) begin
      best_idx_next  = d_idx;
      best_dist_next = d_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ctl.valid) begin
      best_idx  <= best_idx_next;
      best_dist <= best_dist_next;
    end
    if (d_ctl.valid && d_ctl.last) begin
      result.best_index    <= IDX_W'(best_idx_next);
      result.best_distance <= best_dist_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= d_ctl.valid && d_ctl.last;
    end
  end

endmodule
`default_nettype wire

[rtl/ncrs_checker.sv]
`default_nettype none
`include "nearest_color_redmean_search_assert.svh"
module ncrs_checker
  import ncrs_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire request_t request,
  input wire logic     result_valid,
  input wire result_t  result
);

  `NCRS_ASSERT_NOW(a_result_after_busy, result_valid, $past(busy) && !busy)
  `NCRS_ASSERT_NEXT(a_result_one_cycle, result_valid, !result_valid)
  `NCRS_ASSERT_NEXT(a_query_sets_busy, start && !busy && request.action == ACT_QUERY, busy)
  `NCRS_ASSERT_NEXT(a_load_no_busy, start && !busy && request.action == ACT_LOAD, !busy && !result_valid)
  `NCRS_ASSERT_NOW(a_result_index_known, result_valid, !$isunknown(result.best_index))

endmodule

bind nearest_color_redmean_search ncrs_checker u_ncrs_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .request     (request),
  .result_valid(result_valid),
  .result      (result)
);
`default_nettype wire

[bench/nearest_color_redmean_search_test.sv]
`timescale 1ns / 1ps
module nearest_color_redmean_search_test
  import ncrs_pkg::*;
();

  localparam int LOAD_SETTLE    = 8;
  localparam int END_DRAIN      = 20;
  localparam int QUIET_LIMIT    = 6000;
  localparam int RANDOM_ITEMS   = 580;
  localparam int MISMATCH_SHOWN = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  request_t         request = '0;
  logic             result_valid;
  result_t          result;
  logic             tile_count_we = 1'b0;
  logic [CNT_W-1:0] tile_count_data = '0;

  nearest_color_redmean_search dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .request         (request),
    .result_valid    (result_valid),
    .result          (result),
    .tile_count_we   (tile_count_we),
    .tile_count_data (tile_count_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // stimulus and predicted answers
  request_t queued_requests[$];
  result_t  awaited_matches[$];

  // predictor state
  color_t           tile_table [MAX_TILES_DEF];
  logic [CNT_W-1:0] tile_limit;
  result_t          want;
  color_t           probe;

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  bit  took = 1'b0;
  int  burst_left = 1;
  int  gap_left = 0;

  // generator view of the table
  bit     gen_written [MAX_TILES_DEF];
  color_t gen_colors [MAX_TILES_DEF];
  int     gen_span = 1;
  int     random_left;
  int     span_pick;
  int     chunk;

  function automatic logic [DIST_W-1:0] redmean_distance(color_t a, color_t b);
    int unsigned dr, dg, db, rm;
    dr = (a.red > b.red) ? 32'(a.red - b.red) : 32'(b.red - a.red);
    dg = (a.green > b.green) ? 32'(a.green - b.green) : 32'(b.green - a.green);
    db = (a.blue > b.blue) ? 32'(a.blue - b.blue) : 32'(b.blue - a.blue);
    rm = (32'(a.red) + 32'(b.red)) >> 1;
    return DIST_W'((WT_R_BASE + rm) * dr * dr + 1024 * dg * dg
                   + (WT_B_BASE - rm) * db * db);
  endfunction

  function automatic result_t nearest_tile(color_t q, logic [CNT_W-1:0] cnt);
    int unsigned n;
    logic [DIST_W-1:0] d;
    result_t r;
    n = 32'(cnt);
    if (n == 0) n = 1;
    if (n > MAX_TILES_DEF) n = MAX_TILES_DEF;
    r.best_index = '0;
    r.best_distance = redmean_distance(tile_table[0], q);
    for (int unsigned i = 1; i < n; i++) begin
      d = redmean_distance(tile_table[i], q);
      if (d < r.best_distance) begin
        r.best_distance = d;
        r.best_index = i[IDX_W-1:0];
      end
    end
    return r;
  endfunction

  // monitor and predictor
  always @(posedge clk) begin
    if (rst) begin
      tile_limit = CNT_W'(1);
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (result_valid) begin
        if (awaited_matches.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MISMATCH_SHOWN)
            $display("unexpected result: index %0d distance %0d",
                     result.best_index, result.best_distance);
        end else begin
          want = awaited_matches.pop_front();
          if (result.best_index !== want.best_index ||
              result.best_distance !== want.best_distance) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN)
              $display("mismatch: expected index %0d distance %0d, got index %0d distance %0d",
                       want.best_index, want.best_distance,
                       result.best_index, result.best_distance);
          end
        end
      end
      if (tile_count_we) tile_limit = tile_count_data;
      if (start && !busy) begin
        probe = '{red: request.red, green: request.green, blue: request.blue};
        if (request.action == ACT_QUERY) begin
          awaited_matches.push_back(nearest_tile(probe, tile_limit));
        end else begin
          tile_table[request.tile_index] = probe;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // driver: bursts of transfers with random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold until the block takes it
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (queued_requests.size() != 0) begin
      request <= queued_requests.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        if ($urandom_range(0, 9) == 0) begin
          burst_left <= 64;
          gap_left <= 0;
        end else begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= $urandom_range(0, 10);
        end
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  task automatic add_load(int idx, color_t c);
    request_t q;
    q.action = ACT_LOAD;
    q.tile_index = idx[IDX_W-1:0];
    q.red = c.red;
    q.green = c.green;
    q.blue = c.blue;
    queued_requests.push_back(q);
    gen_written[idx] = 1'b1;
    gen_colors[idx] = c;
  endtask

  task automatic add_query(color_t c);
    request_t q;
    q.action = ACT_QUERY;
    q.tile_index = IDX_W'($urandom_range(0, MAX_TILES_DEF - 1));
    q.red = c.red;
    q.green = c.green;
    q.blue = c.blue;
    queued_requests.push_back(q);
  endtask

  function automatic color_t random_color();
    color_t c;
    case ($urandom_range(0, 3))
      0: begin
        c.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        c.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        c.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1: begin
        // coarse palette so that ties show up
        c.red = CH_W'(8'h40 * $urandom_range(0, 3));
        c.green = CH_W'(8'h40 * $urandom_range(0, 3));
        c.blue = CH_W'(8'h40 * $urandom_range(0, 3));
      end
      default: begin
        c = 24'($urandom);
      end
    endcase
    return c;
  endfunction

  // wait until the block is quiet
  task automatic settle_idle();
    while (queued_requests.size() != 0 || awaited_matches.size() != 0 || start || busy)
      @(posedge clk);
  endtask

  task automatic write_tile_count(logic [CNT_W-1:0] v);
    settle_idle();
    repeat (LOAD_SETTLE) @(negedge clk);
    tile_count_we <= 1'b1;
    tile_count_data <= v;
    @(negedge clk);
    tile_count_we <= 1'b0;
    if (v == 0) gen_span = 1;
    else if (v > MAX_TILES_DEF) gen_span = MAX_TILES_DEF;
    else gen_span = int'(v);
  endtask

  task automatic run_random(int k);
    int idx;
    for (int i = 0; i < gen_span; i++)
      if (!gen_written[i]) add_load(i, random_color());
    repeat (k) begin
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 9) < 4)
          add_query(gen_colors[$urandom_range(0, gen_span - 1)]);
        else
          add_query(random_color());
      end else begin
        if ($urandom_range(0, 9) < 7) idx = $urandom_range(0, gen_span - 1);
        else idx = $urandom_range(0, MAX_TILES_DEF - 1);
        add_load(idx, random_color());
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // reset count of one entry
    add_load(0, 24'h000000);
    add_query(24'h000000);
    add_query(24'hFFFFFF);
    add_load(0, 24'hFFFFFF);
    add_query(24'h000000);
    add_query(24'hFFFFFF);
    add_load(MAX_TILES_DEF - 1, 24'h5AA53C);

    // zero count searches entry 0 only
    write_tile_count(CNT_W'(0));
    add_query(24'h5AA53C);

    // ties keep the first index
    write_tile_count(CNT_W'(3));
    add_load(1, 24'hFFFFFF);
    add_load(2, 24'hFFFFFF);
    add_query(24'h808080);
    add_load(1, 24'hFEFFFF);
    add_query(24'hFFFFFF);
    add_query(24'hFEFFFF);
    add_load(2, 24'h00FF00);
    add_query(24'h00FF00);

    // oversized count saturates to the full table
    write_tile_count({CNT_W{1'b1}});
    run_random(6);
    write_tile_count(CNT_W'(MAX_TILES_DEF));
    run_random(4);

    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      span_pick = $urandom_range(0, 19);
      if (span_pick < 2) write_tile_count(CNT_W'(0));
      else if (span_pick == 2) write_tile_count(CNT_W'($urandom_range(41, 200)));
      else write_tile_count(CNT_W'($urandom_range(1, 40)));
      chunk = $urandom_range(10, 40);
      if (chunk > random_left) chunk = random_left;
      run_random(chunk);
      random_left -= chunk;
    end

    settle_idle();
    repeat (END_DRAIN) @(posedge clk);
    if (mismatch_count == 0 && awaited_matches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
